[src/rfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the response frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

	localparam logic [7:0] BUF_BYTES = 8'd255;

	localparam int WIN = 12;

	// control bytes
	localparam logic [7:0] CH_STX   = 8'h01;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_PST2  = 8'h04;
	localparam logic [7:0] CH_PST1  = 8'h05;
	localparam logic [7:0] CH_NAK   = 8'h15;
	localparam logic [7:0] CH_SYN   = 8'h16;
	localparam logic [7:0] CH_REP_A = 8'h1A;
	localparam logic [7:0] CH_REP_B = 8'h1B;
	localparam logic [7:0] LEN_AUTO = 8'hFF;
	localparam logic [3:0] BCC_HI   = 4'h3;

	// LEN carries 20h bias plus the 11 fixed bytes
	localparam logic [8:0] LEN_OFFSET = 9'd43;
	localparam logic [8:0] MIN_FRAME  = 9'd17;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// action codes
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// verdict codes
	localparam logic [2:0] E_OK      = 3'd0;
	localparam logic [2:0] E_TIMEOUT = 3'd1;
	localparam logic [2:0] E_NAK     = 3'd2;
	localparam logic [2:0] E_BAD     = 3'd3;
	localparam logic [2:0] E_BCC     = 3'd4;
	localparam logic [2:0] E_OVF     = 3'd5;

	// register indexes
	localparam logic REG_TIMEOUT = 1'b0;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  error_code;
		logic [7:0]  seq_echo;
		logic [7:0]  cmd_echo;
		logic [7:0]  data_length;
		logic [47:0] status_word;
	} out_word_t;

endpackage

[src/rfd_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_regs
// APB-style register port holding the response timeout.
// ----------------------------------------------------------------------------
module rfd_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] timeout_ticks
);

	logic [15:0] timeout_q;

	assign pready = 1'b1;
	assign timeout_ticks = timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rfd_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == rfd_pkg::REG_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			rfd_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

[src/rfd_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_engine
// Frame state, delay window, running sum and the per-word decision logic.
// ----------------------------------------------------------------------------
module rfd_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  rfd_pkg::in_word_t  item,
	input  logic [15:0]        timeout_ticks,
	output logic               res_valid,
	output rfd_pkg::out_word_t res
);

	localparam logic PH_HUNT  = 1'b0;
	localparam logic PH_FRAME = 1'b1;

	logic        phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] sum_q, sum_d;
	logic [10:0] sum8_q, sum8_d;   // sum of window positions 0..7
	logic [7:0]  win_q [rfd_pkg::WIN];
	logic [7:0]  win_d [rfd_pkg::WIN];
	logic [7:0]  len_q, len_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] ticks_q, ticks_d;

	// frame judgment
	logic [8:0]  n9, dl9;
	logic        short_f, len_bad, pst_bad, nib_bad, bcc_bad, stat_bad;
	logic [15:0] got, chk;
	logic [2:0]  fin_code;
	logic [47:0] status;
	logic [7:0]  b;

	assign b = item.rx_byte;

	always_comb begin
		n9 = {1'b0, count_q} + 9'd1;
		short_f = n9 < rfd_pkg::MIN_FRAME;
		if (len_q == rfd_pkg::LEN_AUTO) begin
			dl9 = n9 - rfd_pkg::MIN_FRAME;
			len_bad = 1'b0;
		end else begin
			dl9 = {1'b0, len_q} - rfd_pkg::LEN_OFFSET;
			len_bad = ({1'b0, len_q} < rfd_pkg::LEN_OFFSET) ||
				(n9 != dl9 + rfd_pkg::MIN_FRAME);
		end
		pst_bad = (win_q[0] != rfd_pkg::CH_PST2) || (win_q[7] != rfd_pkg::CH_PST1);
		nib_bad = (win_q[8][7:4] != rfd_pkg::BCC_HI) || (win_q[9][7:4] != rfd_pkg::BCC_HI) ||
			(win_q[10][7:4] != rfd_pkg::BCC_HI) || (win_q[11][7:4] != rfd_pkg::BCC_HI);
		got = {win_q[8][3:0], win_q[9][3:0], win_q[10][3:0], win_q[11][3:0]};
		chk = sum_q + {5'd0, sum8_q};
		bcc_bad = nib_bad || (got != chk);
		stat_bad = !(win_q[1][7] && win_q[2][7] && win_q[3][7] &&
			win_q[4][7] && win_q[5][7] && win_q[6][7]);
		status = {win_q[1], win_q[2], win_q[3], win_q[4], win_q[5], win_q[6]};
		if (short_f || len_bad || pst_bad)
			fin_code = rfd_pkg::E_BAD;
		else if (bcc_bad)
			fin_code = rfd_pkg::E_BCC;
		else if (stat_bad)
			fin_code = rfd_pkg::E_BAD;
		else
			fin_code = rfd_pkg::E_OK;
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		sum_d   = sum_q;
		sum8_d  = sum8_q;
		win_d   = win_q;
		len_d   = len_q;
		seq_d   = seq_q;
		cmd_d   = cmd_q;
		ticks_d = ticks_q;
		res_valid = 1'b0;
		res = '0;
		res.out_kind = rfd_pkg::KIND_VERDICT;

		if (item.action == rfd_pkg::ACT_TICK) begin
			if (ticks_q <= 16'd1) begin
				res_valid = 1'b1;
				res.error_code = rfd_pkg::E_TIMEOUT;
				phase_d = PH_HUNT;
				ticks_d = timeout_ticks;
			end else begin
				ticks_d = ticks_q - 16'd1;
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					case (b)
						rfd_pkg::CH_SYN: ticks_d = timeout_ticks;
						rfd_pkg::CH_NAK: begin
							res_valid = 1'b1;
							res.error_code = rfd_pkg::E_NAK;
							ticks_d = timeout_ticks;
						end
						rfd_pkg::CH_REP_A, rfd_pkg::CH_REP_B: begin
							res_valid = 1'b1;
							res.error_code = rfd_pkg::E_BAD;
							ticks_d = timeout_ticks;
						end
						rfd_pkg::CH_STX: begin
							phase_d = PH_FRAME;
							count_d = 8'd1;
							sum_d   = '0;
							sum8_d  = '0;
							for (int i = 0; i < rfd_pkg::WIN; i++)
								win_d[i] = '0;
						end
						default: ;
					endcase
				end
				PH_FRAME: begin
					if (count_q >= rfd_pkg::BUF_BYTES) begin
						// dropped byte, even if it is ETX
						res_valid = 1'b1;
						res.error_code = rfd_pkg::E_OVF;
						phase_d = PH_HUNT;
						ticks_d = timeout_ticks;
					end else if (b == rfd_pkg::CH_ETX) begin
						res_valid = 1'b1;
						res.error_code = fin_code;
						if (fin_code == rfd_pkg::E_OK) begin
							res.seq_echo    = seq_q;
							res.cmd_echo    = cmd_q;
							res.data_length = dl9[7:0];
							res.status_word = status;
						end
						phase_d = PH_HUNT;
						ticks_d = timeout_ticks;
					end else begin
						count_d = count_q + 8'd1;
						if (count_q < 8'd4) begin
							if (count_q == 8'd1)
								len_d = b;
							else if (count_q == 8'd2)
								seq_d = b;
							else
								cmd_d = b;
							sum_d = sum_q + {8'd0, b};
						end else begin
							for (int i = 0; i < rfd_pkg::WIN - 1; i++)
								win_d[i] = win_q[i + 1];
							win_d[rfd_pkg::WIN - 1] = b;
							sum8_d = sum8_q - {3'd0, win_q[0]} + {3'd0, win_q[8]};
							// byte leaving the window is payload
							if (count_q >= 8'd16) begin
								sum_d = sum_q + {8'd0, win_q[0]};
								res_valid = 1'b1;
								res.out_kind = rfd_pkg::KIND_PAYLOAD;
								res.payload_byte = win_q[0];
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			sum8_q  <= '0;
			for (int i = 0; i < rfd_pkg::WIN; i++)
				win_q[i] <= '0;
			len_q   <= '0;
			seq_q   <= '0;
			cmd_q   <= '0;
			ticks_q <= rfd_pkg::TIMEOUT_RESET;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			sum8_q  <= sum8_d;
			win_q   <= win_d;
			len_q   <= len_d;
			seq_q   <= seq_d;
			cmd_q   <= cmd_d;
			ticks_q <= ticks_d;
		end
	end

endmodule

[src/response_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_frame_deframer
// STX/ETX response deframer with ASCII nibble sum check and timeout.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one word per received byte or
// per timer tick. Output channel (out_valid/out_stall/out_data): tentative
// payload bytes and one verdict per frame, NAK, stray reply code, overflow
// or timeout. At most one output word per input word.
// A word is held in the input register, judged there by the engine and its
// result lands in the output register. Throughput is one word per cycle
// while the receiver does not stall; the frame state update (window shift,
// sums, tick count) is done in a single step of the engine.
// When the receiver stalls, the output register holds its word; the input
// register still takes one more word, and then in_stall rises until the
// output frees up.
// Reset puts the block in hunt with the timeout count at 1000 ticks and the
// timeout register at 1000. The timeout register sits at byte address 0; it
// must be written only while no word is in flight (not enforced by the block).
// ----------------------------------------------------------------------------
module response_frame_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rfd_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rfd_pkg::out_word_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic               valid_s1;
	rfd_pkg::in_word_t  item_s1;
	logic               adv_s1, step;
	logic               res_valid;
	rfd_pkg::out_word_t res;
	logic               out_valid_q;
	rfd_pkg::out_word_t out_q;
	logic [15:0]        timeout_ticks;

	assign adv_s1   = !out_valid_q || !out_stall;
	assign step     = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	rfd_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.timeout_ticks(timeout_ticks)
	);

	rfd_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.item         (item_s1),
		.timeout_ticks(timeout_ticks),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	// stall only while the input register holds a word that cannot move
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked word");

	// a held input word is still there next cycle
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(item_s1))
		else $error("held input word lost");

	// payload words carry no verdict
	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == rfd_pkg::KIND_PAYLOAD |->
		out_data.error_code == rfd_pkg::E_OK)
		else $error("payload word with error code");

	// failed verdicts echo nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != rfd_pkg::E_OK |->
		out_data.status_word == '0 && out_data.data_length == '0 &&
		out_data.seq_echo == '0 && out_data.cmd_echo == '0)
		else $error("failed verdict carries frame fields");

endmodule
